// ----- hw/rtl/eimr_pkg.sv -----
// Package for the ellipse interaction-matrix row block: widths, codes, saturating helpers.
// No dependencies.
package eimr_pkg;
    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS = 24;
    localparam int NUM_ROWS = 5;
    localparam int KIND_W = 3;
    localparam int CFG_IDX_W = 2;
    localparam int QUEUE_DEPTH = 2;

    typedef logic signed [DATA_WIDTH-1:0] t_word;
    typedef logic [NUM_ROWS-1:0] t_sel;
    typedef logic [KIND_W-1:0] t_kind;

    localparam t_kind KIND_X = 3'd0;
    localparam t_kind KIND_Y = 3'd1;
    localparam t_kind KIND_M20 = 3'd2;
    localparam t_kind KIND_M11 = 3'd3;
    localparam t_kind KIND_M02 = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_PLANE_A = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_B = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_C = 2'd2;

    localparam t_word W_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam t_word W_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam t_word W_ONE = t_word'(64'sd1 <<< FRAC_BITS);
    localparam t_word W_NEG_ONE = t_word'(-(64'sd1 <<< FRAC_BITS));

    typedef struct packed {
        t_word x;
        t_word y;
        t_word m20;
        t_word m11;
        t_word m02;
        t_sel  sel;
    } t_item;

    typedef struct packed {
        t_kind kind;
        t_word vx;
        t_word vy;
        t_word vz;
        t_word wx;
        t_word wy;
        t_word wz;
        logic  last;
    } t_row;

    function automatic t_word sadd(input t_word a, input t_word b);
        logic signed [DATA_WIDTH:0] s;
        s = {a[DATA_WIDTH-1], a} + {b[DATA_WIDTH-1], b};
        if (s[DATA_WIDTH] != s[DATA_WIDTH-1]) begin
            return s[DATA_WIDTH] ? W_MIN : W_MAX;
        end
        return s[DATA_WIDTH-1:0];
    endfunction

    function automatic t_word ssub(input t_word a, input t_word b);
        logic signed [DATA_WIDTH:0] s;
        s = {a[DATA_WIDTH-1], a} - {b[DATA_WIDTH-1], b};
        if (s[DATA_WIDTH] != s[DATA_WIDTH-1]) begin
            return s[DATA_WIDTH] ? W_MIN : W_MAX;
        end
        return s[DATA_WIDTH-1:0];
    endfunction

    function automatic t_word sneg(input t_word a);
        return (a == W_MIN) ? W_MAX : -a;
    endfunction

    function automatic t_word smul(input t_word a, input t_word b);
        logic signed [2*DATA_WIDTH-1:0] p;
        logic signed [2*DATA_WIDTH:0] r;
        logic signed [2*DATA_WIDTH-FRAC_BITS:0] q;
        p = (2*DATA_WIDTH)'(a) * (2*DATA_WIDTH)'(b);
        r = {p[2*DATA_WIDTH-1], p} + ((2*DATA_WIDTH+1)'(1) <<< (FRAC_BITS-1));
        q = r[2*DATA_WIDTH:FRAC_BITS];
        if (q > $signed({{(DATA_WIDTH-FRAC_BITS+1){1'b0}}, W_MAX})) begin
            return W_MAX;
        end
        if (q < $signed({{(DATA_WIDTH-FRAC_BITS+1){1'b1}}, W_MIN})) begin
            return W_MIN;
        end
        return q[DATA_WIDTH-1:0];
    endfunction
endpackage

// ----- hw/rtl/eimr_if.sv -----
// Valid/ready channel carrying one payload beat.
// No package dependency; the payload type is the parameter T.
interface eimr_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/eimr_front.sv -----
// Front end: accepts items, computes shared products (iz, A*x, ...) in two stages.
// Depends on eimr_pkg.
module eimr_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  eimr_pkg::t_item     i_item,
    input  logic                i_valid,
    output logic                o_ready,
    input  eimr_pkg::t_word     i_a,
    input  eimr_pkg::t_word     i_b,
    input  eimr_pkg::t_word     i_c,
    output logic                o_valid,
    output eimr_pkg::t_item     o_item,
    output eimr_pkg::t_word     o_iz,
    input  logic                i_ready
);
    logic            r_v1, r_v2;
    eimr_pkg::t_item r_it1, r_it2;
    eimr_pkg::t_word r_ax, r_by, r_iz;
    logic            adv2, adv1;

    assign adv2 = !r_v2 || i_ready;
    assign adv1 = !r_v1 || adv2;
    assign o_ready = adv1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (adv1) begin
                r_v1 <= i_valid;
            end
            if (adv2) begin
                r_v2 <= r_v1;
            end
        end
        if (adv1 && i_valid) begin
            r_it1 <= i_item;
            r_ax  <= eimr_pkg::smul(i_a, i_item.x);
            r_by  <= eimr_pkg::smul(i_b, i_item.y);
        end
        if (adv2 && r_v1) begin
            r_it2 <= r_it1;
            r_iz  <= eimr_pkg::sadd(eimr_pkg::sadd(r_ax, r_by), i_c);
        end
    end

    assign o_valid = r_v2;
    assign o_item = r_it2;
    assign o_iz = r_iz;
endmodule

// ----- hw/rtl/eimr_queue.sv -----
// Small FIFO between the front and back ends.
// Depends on eimr_pkg.
module eimr_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  eimr_pkg::t_item   i_item,
    input  eimr_pkg::t_word   i_iz,
    output logic              o_ready,
    output logic              o_valid,
    output eimr_pkg::t_item   o_item,
    output eimr_pkg::t_word   o_iz,
    input  logic              i_ready
);
    localparam int AW = $clog2(eimr_pkg::QUEUE_DEPTH);
    eimr_pkg::t_item r_item [eimr_pkg::QUEUE_DEPTH];
    eimr_pkg::t_word r_iz [eimr_pkg::QUEUE_DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic          push, pop;

    assign o_ready = r_cnt != (AW+1)'(eimr_pkg::QUEUE_DEPTH);
    assign o_valid = r_cnt != '0;
    assign push = i_valid && o_ready;
    assign pop = o_valid && i_ready;
    assign o_item = r_item[r_rp];
    assign o_iz = r_iz[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(push) - (AW+1)'(pop);
        end
        if (push) begin
            r_item[r_wp] <= i_item;
            r_iz[r_wp] <= i_iz;
        end
    end
endmodule

// ----- hw/rtl/eimr_back.sv -----
// Back end: walks the selection mask one row per cycle when not stalled, through a three-stage datapath.
// Depends on eimr_pkg.
module eimr_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  eimr_pkg::t_item   i_item,
    input  eimr_pkg::t_word   i_iz,
    output logic              o_ready,
    input  eimr_pkg::t_word   i_a,
    input  eimr_pkg::t_word   i_b,
    input  eimr_pkg::t_word   i_c,
    output logic              o_valid,
    output eimr_pkg::t_row    o_row,
    input  logic              i_ready
);
    typedef struct packed {
        eimr_pkg::t_kind kind;
        logic            last;
        eimr_pkg::t_word x, y, m20, m11, m02, iz;
    } t_ctx;

    // stage 1 products
    typedef struct packed {
        eimr_pkg::t_word p0, p1, p2, p3, p4, p5, p6, p7, p8, p9, p10;
    } t_p1;

    eimr_pkg::t_sel r_rem;
    logic           r_busy;
    t_ctx           r_item_ctx;
    logic           issue, adv1, adv2, adv3;
    logic           r_v1, r_v2, r_v3;
    t_ctx           r_c1, r_c2;
    t_p1            r_p1, r_p2, n_p1, n_p2;
    eimr_pkg::t_row r_out, n_out;
    eimr_pkg::t_sel cur_sel, low_bit, rest;
    eimr_pkg::t_kind kind;
    t_ctx           ctx;

    assign cur_sel = r_busy ? r_rem : i_item.sel;
    assign low_bit = cur_sel & (~cur_sel + 1'b1);
    assign rest = cur_sel & ~low_bit;

    always_comb begin
        kind = eimr_pkg::KIND_X;
        for (int k = 0; k < eimr_pkg::NUM_ROWS; k++) begin
            if (low_bit[k]) begin
                kind = eimr_pkg::t_kind'(k);
            end
        end
    end

    always_comb begin
        ctx = r_item_ctx;
        if (!r_busy) begin
            ctx.x = i_item.x;
            ctx.y = i_item.y;
            ctx.m20 = i_item.m20;
            ctx.m11 = i_item.m11;
            ctx.m02 = i_item.m02;
            ctx.iz = i_iz;
        end
        ctx.kind = kind;
        ctx.last = rest == '0;
    end

    assign adv3 = !r_v3 || i_ready;
    assign adv2 = !r_v2 || adv3;
    assign adv1 = !r_v1 || adv2;
    assign issue = adv1 && (r_busy || (i_valid && i_item.sel != '0));
    assign o_ready = adv1 && !r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (issue) begin
                r_busy <= rest != '0;
            end
            if (adv1) begin
                r_v1 <= issue;
            end
            if (adv2) begin
                r_v2 <= r_v1;
            end
            if (adv3) begin
                r_v3 <= r_v2;
            end
        end
        if (issue) begin
            r_rem <= rest;
            r_item_ctx <= ctx;
        end
        if (adv1 && issue) begin
            r_c1 <= ctx;
            r_p1 <= n_p1;
        end
        if (adv2 && r_v1) begin
            r_c2 <= r_c1;
            r_p2 <= n_p2;
        end
        if (adv3 && r_v2) begin
            r_out <= n_out;
        end
    end

    // stage 1: first-level products per row kind
    always_comb begin
        n_p1 = '0;
        unique case (ctx.kind)
            eimr_pkg::KIND_X: begin
                n_p1.p0 = eimr_pkg::smul(ctx.x, ctx.iz);
                n_p1.p1 = eimr_pkg::smul(i_a, ctx.m20);
                n_p1.p2 = eimr_pkg::smul(i_b, ctx.m11);
                n_p1.p3 = eimr_pkg::smul(ctx.x, ctx.y);
                n_p1.p4 = eimr_pkg::smul(ctx.x, ctx.x);
            end
            eimr_pkg::KIND_Y: begin
                n_p1.p0 = eimr_pkg::smul(ctx.y, ctx.iz);
                n_p1.p1 = eimr_pkg::smul(i_a, ctx.m11);
                n_p1.p2 = eimr_pkg::smul(i_b, ctx.m02);
                n_p1.p3 = eimr_pkg::smul(ctx.y, ctx.y);
                n_p1.p4 = eimr_pkg::smul(ctx.x, ctx.y);
            end
            eimr_pkg::KIND_M20: begin
                n_p1.p0 = eimr_pkg::smul(i_a, ctx.m20);
                n_p1.p1 = eimr_pkg::smul(i_b, ctx.m11);
                n_p1.p2 = eimr_pkg::smul(i_a, ctx.x);
                n_p1.p3 = eimr_pkg::smul(i_b, ctx.x);
                n_p1.p4 = eimr_pkg::smul(ctx.y, ctx.m20);
                n_p1.p5 = eimr_pkg::smul(ctx.x, ctx.m11);
                n_p1.p6 = eimr_pkg::smul(ctx.m20, ctx.x);
            end
            eimr_pkg::KIND_M11: begin
                n_p1.p0 = eimr_pkg::smul(i_a, ctx.m11);
                n_p1.p1 = eimr_pkg::smul(i_b, ctx.m02);
                n_p1.p2 = eimr_pkg::smul(i_a, ctx.m20);
                n_p1.p3 = eimr_pkg::smul(i_b, ctx.m11);
                n_p1.p4 = eimr_pkg::smul(i_a, ctx.y);
                n_p1.p5 = eimr_pkg::smul(i_b, ctx.x);
                n_p1.p6 = eimr_pkg::smul(ctx.y, ctx.m11);
                n_p1.p7 = eimr_pkg::smul(ctx.x, ctx.m02);
                n_p1.p8 = eimr_pkg::smul(ctx.y, ctx.m20);
                n_p1.p9 = eimr_pkg::smul(ctx.x, ctx.m11);
            end
            default: begin
                n_p1.p0 = eimr_pkg::smul(i_a, ctx.m11);
                n_p1.p1 = eimr_pkg::smul(i_b, ctx.m02);
                n_p1.p2 = eimr_pkg::smul(i_b, ctx.y);
                n_p1.p3 = eimr_pkg::smul(i_a, ctx.y);
                n_p1.p4 = eimr_pkg::smul(ctx.y, ctx.m02);
                n_p1.p5 = eimr_pkg::smul(ctx.y, ctx.m11);
                n_p1.p6 = eimr_pkg::smul(ctx.x, ctx.m02);
            end
        endcase
    end

    // stage 2: second-level products; pass-through of the rest
    always_comb begin
        n_p2 = r_p1;
        unique case (r_c1.kind)
            eimr_pkg::KIND_M20: begin
                n_p2.p7 = eimr_pkg::smul(eimr_pkg::sadd(r_c1.iz, r_p1.p2), r_c1.m20);
                n_p2.p8 = eimr_pkg::smul(r_p1.p3, r_c1.m11);
            end
            eimr_pkg::KIND_M11: begin
                n_p2.p4 = eimr_pkg::smul(r_p1.p4, r_c1.m20);
                n_p2.p5 = eimr_pkg::smul(r_p1.p5, r_c1.m02);
                n_p2.p10 = eimr_pkg::smul(eimr_pkg::ssub(eimr_pkg::sadd(eimr_pkg::sadd(
                    r_c1.iz, r_c1.iz), r_c1.iz), i_c), r_c1.m11);
            end
            eimr_pkg::KIND_M02: begin
                n_p2.p7 = eimr_pkg::smul(eimr_pkg::sadd(r_c1.iz, r_p1.p2), r_c1.m02);
                n_p2.p8 = eimr_pkg::smul(r_p1.p3, r_c1.m11);
            end
            default: begin
            end
        endcase
    end

    function automatic eimr_pkg::t_word tw(input eimr_pkg::t_word a);
        return eimr_pkg::sadd(a, a);
    endfunction

    function automatic eimr_pkg::t_word th(input eimr_pkg::t_word a);
        return eimr_pkg::sadd(eimr_pkg::sadd(a, a), a);
    endfunction

    // stage 3: saturating sums
    always_comb begin
        n_out = '0;
        n_out.kind = r_c2.kind;
        n_out.last = r_c2.last;
        unique case (r_c2.kind)
            eimr_pkg::KIND_X: begin
                n_out.vx = eimr_pkg::sneg(r_c2.iz);
                n_out.vz = eimr_pkg::sadd(eimr_pkg::sadd(r_p2.p0, r_p2.p1), r_p2.p2);
                n_out.wx = eimr_pkg::sadd(r_p2.p3, r_c2.m11);
                n_out.wy = eimr_pkg::ssub(eimr_pkg::ssub(eimr_pkg::W_NEG_ONE, r_p2.p4),
                    r_c2.m20);
                n_out.wz = r_c2.y;
            end
            eimr_pkg::KIND_Y: begin
                n_out.vy = eimr_pkg::sneg(r_c2.iz);
                n_out.vz = eimr_pkg::sadd(eimr_pkg::sadd(r_p2.p0, r_p2.p1), r_p2.p2);
                n_out.wx = eimr_pkg::sadd(eimr_pkg::sadd(eimr_pkg::W_ONE, r_p2.p3),
                    r_c2.m02);
                n_out.wy = eimr_pkg::ssub(eimr_pkg::sneg(r_p2.p4), r_c2.m11);
                n_out.wz = eimr_pkg::sneg(r_c2.x);
            end
            eimr_pkg::KIND_M20: begin
                n_out.vx = eimr_pkg::sneg(tw(eimr_pkg::sadd(r_p2.p0, r_p2.p1)));
                n_out.vz = tw(eimr_pkg::sadd(r_p2.p7, r_p2.p8));
                n_out.wx = tw(eimr_pkg::sadd(r_p2.p4, r_p2.p5));
                n_out.wy = eimr_pkg::sneg(eimr_pkg::sadd(tw(r_p2.p6), tw(r_p2.p6)));
                n_out.wz = tw(r_c2.m11);
            end
            eimr_pkg::KIND_M11: begin
                n_out.vx = eimr_pkg::ssub(eimr_pkg::sneg(r_p2.p0), r_p2.p1);
                n_out.vy = eimr_pkg::ssub(eimr_pkg::sneg(r_p2.p2), r_p2.p3);
                n_out.vz = eimr_pkg::sadd(eimr_pkg::sadd(r_p2.p4, r_p2.p10), r_p2.p5);
                n_out.wx = eimr_pkg::sadd(th(r_p2.p6), r_p2.p7);
                n_out.wy = eimr_pkg::ssub(eimr_pkg::sneg(r_p2.p8), th(r_p2.p9));
                n_out.wz = eimr_pkg::ssub(r_c2.m02, r_c2.m20);
            end
            default: begin
                n_out.vy = eimr_pkg::sneg(tw(eimr_pkg::sadd(r_p2.p0, r_p2.p1)));
                n_out.vz = tw(eimr_pkg::sadd(r_p2.p7, r_p2.p8));
                n_out.wx = eimr_pkg::sadd(tw(r_p2.p4), tw(r_p2.p4));
                n_out.wy = eimr_pkg::sneg(tw(eimr_pkg::sadd(r_p2.p5, r_p2.p6)));
                n_out.wz = eimr_pkg::sneg(tw(r_c2.m11));
            end
        endcase
    end

    assign o_valid = r_v3;
    assign o_row = r_out;
endmodule

// ----- hw/rtl/ellipse_interaction_matrix_rows_top.sv -----
// Channel   | Dir | Payload
// in_ch     | in  | eimr_pkg::t_item (center, moments, row_select)
// out_ch    | out | eimr_pkg::t_row (row_kind, six entries, last_row)
// cfg       | in  | i_cfg_we / i_cfg_idx / i_cfg_data (plane A, B, C)
// One row leaves per cycle while out_ch is ready; an item with k selected rows yields k rows,
// an item with an empty selection none; the back end takes the next item after the last row issues.
// Path: two front stages, queue, three back stages through the multiplier pipeline.
// Synchronous active-low reset clears all valid state and sets plane C to 1.0.
// Either side may stall; the queue lets the front keep accepting while rows drain, until it is full.
module ellipse_interaction_matrix_rows_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    eimr_if.sink                                in_ch,
    eimr_if.source                              out_ch,
    input  logic                                i_cfg_we,
    input  logic [eimr_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [eimr_pkg::DATA_WIDTH-1:0]     i_cfg_data
);
    eimr_pkg::t_word r_a, r_b, r_c;
    logic            f_valid, f_ready, q_valid, q_ready;
    eimr_pkg::t_item f_item, q_item;
    eimr_pkg::t_word f_iz, q_iz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a <= '0;
            r_b <= '0;
            r_c <= eimr_pkg::W_ONE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                eimr_pkg::REG_PLANE_A: r_a <= i_cfg_data;
                eimr_pkg::REG_PLANE_B: r_b <= i_cfg_data;
                eimr_pkg::REG_PLANE_C: r_c <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    eimr_front u_front (
        .i_clk, .i_rst_n,
        .i_item(in_ch.data), .i_valid(in_ch.valid), .o_ready(in_ch.ready),
        .i_a(r_a), .i_b(r_b), .i_c(r_c),
        .o_valid(f_valid), .o_item(f_item), .o_iz(f_iz), .i_ready(f_ready)
    );

    eimr_queue u_queue (
        .i_clk, .i_rst_n,
        .i_valid(f_valid), .i_item(f_item), .i_iz(f_iz), .o_ready(f_ready),
        .o_valid(q_valid), .o_item(q_item), .o_iz(q_iz), .i_ready(q_ready)
    );

    eimr_back u_back (
        .i_clk, .i_rst_n,
        .i_valid(q_valid), .i_item(q_item), .i_iz(q_iz), .o_ready(q_ready),
        .i_a(r_a), .i_b(r_b), .i_c(r_c),
        .o_valid(out_ch.valid), .o_row(out_ch.data), .i_ready(out_ch.ready)
    );
endmodule

// ----- hw/rtl/eimr_checker.sv -----
// Port-level checks on the top level, bound in below.
// Depends on eimr_pkg.
module eimr_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            out_valid,
    input logic            out_ready,
    input eimr_pkg::t_row  out_row
);
    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> out_row.kind <= eimr_pkg::KIND_M02)
        else $error("row kind out of range");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_row))
        else $error("stalled beat changed");
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_ready && !out_row.last ##1 out_valid |->
        out_row.kind > $past(out_row.kind))
        else $error("rows out of order");
    a_zero_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && (out_row.kind == eimr_pkg::KIND_X || out_row.kind == eimr_pkg::KIND_M20)
        |-> out_row.vy == '0)
        else $error("structural zero broken");
endmodule

bind ellipse_interaction_matrix_rows_top eimr_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_row(out_ch.data)
);
